### rtl/mcr_pkg.sv
// midpoint circle rasterizer: shared constants
// no dependencies
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int DEC_W = 20;

   localparam int DEC_START     = 3;
   localparam int DEC_STEP_DOWN = 10;
   localparam int DEC_STEP_FLAT = 6;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam logic [2:0] LAST_PIXEL = 3'd7;
   localparam logic [2:0] LAST_SPAN  = 3'd3;

endpackage

### rtl/mcr_front.sv
// front end: accepts start/step words, runs the midpoint decision update
// and pushes one group job per word that draws; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [((3*COORD_WIDTH+31+7)/8)*8-1:0] req_tdata,
   input  logic                      req_tuser,
   output logic                      job_push,
   output logic [4*COORD_WIDTH+33:0] job_data,
   input  logic                      job_full
);
   import mcr_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int EW = (CW > DEC_W) ? CW : DEC_W;

   logic signed [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0]    ox_ff, ox_in, oy_ff, oy_in;
   logic signed [DEC_W-1:0] dec_ff, dec_in;
   logic                    fill_ff, fill_in;
   logic [31:0]             color_ff, color_in;
   logic                    active_ff, active_in;

   logic                    accept, is_start, done;
   logic signed [CW-1:0]    oy_down, ox_up;
   logic [EW-1:0]           x_e, yd_e, d_e, r_e;
   logic [EW-1:0]           dec_down, dec_flat, dec_start;

   assign req_tready = !job_full;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = (req_tuser == MODE_START);

   assign oy_down = oy_ff - CW'(1);
   assign ox_up   = ox_ff + CW'(1);
   assign x_e     = EW'(ox_ff);
   assign yd_e    = EW'(oy_down);
   assign d_e     = EW'(dec_ff);
   assign r_e     = EW'(req_tdata[3*CW-3:2*CW]);

   assign dec_down  = d_e + ((x_e - yd_e) << 2) + EW'(DEC_STEP_DOWN);
   assign dec_flat  = d_e + (x_e << 2) + EW'(DEC_STEP_FLAT);
   assign dec_start = EW'(DEC_START) - (r_e << 1);

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      dec_in    = dec_ff;
      fill_in   = fill_ff;
      color_in  = color_ff;
      active_in = active_ff;
      done      = 1'b0;
      job_push  = 1'b0;
      if (accept) begin
         if (is_start) begin
            cx_in     = req_tdata[CW-1:0];
            cy_in     = req_tdata[2*CW-1:CW];
            ox_in     = '0;
            oy_in     = CW'(req_tdata[3*CW-3:2*CW]);
            dec_in    = dec_start[DEC_W-1:0];
            fill_in   = req_tdata[3*CW-2];
            color_in  = req_tdata[3*CW+30:3*CW-1];
            active_in = 1'b1;
            job_push  = 1'b1;
         end else if (active_ff) begin
            if (dec_ff > 0) begin
               oy_in  = oy_down;
               dec_in = dec_down[DEC_W-1:0];
            end else begin
               dec_in = dec_flat[DEC_W-1:0];
            end
            ox_in     = ox_up;
            done      = (oy_in < ox_up);
            active_in = !done;
            job_push  = 1'b1;
         end
      end
   end

   // job layout from bit 0: cx, cy, ox, oy, fill, color, done
   assign job_data = {done, color_in, fill_in, oy_in, ox_in, cy_in, cx_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      dec_ff   <= dec_in;
      fill_ff  <= fill_in;
      color_ff <= color_in;
   end

endmodule

### rtl/mcr_queue.sv
// two-entry job queue between front and back end
// no dependencies
`timescale 1ns / 1ps

module mcr_queue #(
   parameter int WIDTH = 98
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mcr_back.sv
// back end: expands one group job into pixels or spans, one rectangle
// per cycle into the output register unless rsp_tready holds it; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  logic [4*COORD_WIDTH+33:0] job_data,
   output logic                      job_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [((3*COORD_WIDTH+34+7)/8)*8-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import mcr_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int OUT_W = ((3*CW+34+7)/8)*8;

   logic signed [CW-1:0] cx, cy, ox, oy, a, b;
   logic                 fill, done;
   logic [31:0]          color;
   logic [2:0]           idx_ff, idx_in;
   logic                 swap, xneg, yneg, last, load;
   logic signed [CW:0]   rx, ry;
   logic [CW-2:0]        rw;
   logic [OUT_W-1:0]     data_ff, data_in;
   logic                 valid_ff, valid_in, last_ff, last_in, done_ff, done_in;

   assign cx    = job_data[CW-1:0];
   assign cy    = job_data[2*CW-1:CW];
   assign ox    = job_data[3*CW-1:2*CW];
   assign oy    = job_data[4*CW-1:3*CW];
   assign fill  = job_data[4*CW];
   assign color = job_data[4*CW+32:4*CW+1];
   assign done  = job_data[4*CW+33];

   // outline: idx bit 0 flips x, bit 1 flips y, bit 2 swaps offsets
   // spans: always left edge, bit 0 flips y, bit 1 swaps offsets
   assign swap = fill ? idx_ff[1] : idx_ff[2];
   assign xneg = fill | idx_ff[0];
   assign yneg = fill ? idx_ff[0] : idx_ff[1];
   assign a    = swap ? oy : ox;
   assign b    = swap ? ox : oy;
   assign last = fill ? (idx_ff == LAST_SPAN) : (idx_ff == LAST_PIXEL);

   assign rx = xneg ? ((CW+1)'(cx) - (CW+1)'(a)) : ((CW+1)'(cx) + (CW+1)'(a));
   assign ry = yneg ? ((CW+1)'(cy) - (CW+1)'(b)) : ((CW+1)'(cy) + (CW+1)'(b));
   assign rw = fill ? {a[CW-3:0], 1'b1} : (CW-1)'(1);

   assign load    = job_valid && (!valid_ff || rsp_tready);
   assign job_pop = load && last;

   always_comb begin
      data_in  = data_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         data_in                    = '0;
         data_in[CW:0]              = rx;
         data_in[2*CW+1:CW+1]       = ry;
         data_in[3*CW:2*CW+2]       = rw;
         data_in[3*CW+1]            = 1'b1;
         data_in[3*CW+33:3*CW+2]    = color;
         last_in                    = last;
         done_in                    = done;
         valid_in                   = 1'b1;
         idx_in                     = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

### rtl/midpoint_circle_rasterizer_core.sv
// Midpoint circle rasterizer. A start word (tuser 0) loads center, radius,
// fill flag and color and emits the group for offset (0, r); each step word
// (tuser 1) advances the midpoint decision and emits the next group, and a
// step while idle emits nothing. A group is eight 1x1 pixels in outline mode
// or four one-row spans in fill mode; rsp_tlast marks the last rectangle of
// a group and rsp_tuser marks every rectangle of the group that ends the
// circle. The front end takes one word per cycle into a two-entry job queue
// unless the queue is full; the back end sends one rectangle per cycle
// unless rsp_tready holds the output register.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius, fill, color
   input  logic [((3*COORD_WIDTH+31+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rect_x, rect_y, rect_width, rect_height, rect_color
   output logic [((3*COORD_WIDTH+34+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,
   // drawing_done
   output logic rsp_tuser
);

   localparam int JOB_W = 4*COORD_WIDTH+34;

   logic             push, full, pop, head_valid;
   logic [JOB_W-1:0] push_data, head_data;

   mcr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_push   (push),
      .job_data   (push_data),
      .job_full   (full)
   );

   mcr_queue #(.WIDTH(JOB_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   mcr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job_data   (head_data),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/testbench.sv
// self-checking bench for midpoint_circle_rasterizer_core: directed and random
// start/step words with a built-in circle predictor and an in-order result scoreboard
// depends on mcr_pkg and the rtl of midpoint_circle_rasterizer_core
`timescale 1ns / 1ps

module testbench;
   import mcr_pkg::*;

   localparam int CW     = 16;
   localparam int REQ_W  = ((3*CW+31+7)/8)*8;
   localparam int RSP_W  = ((3*CW+34+7)/8)*8;
   localparam int NUM_RANDOM = 176;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [16:0] x;
      logic [16:0] y;
      logic [14:0] w;
      logic        h;
      logic [31:0] color;
      logic        last;
      logic        done;
   } rect_type;

   typedef struct packed {
      logic             mode;
      logic [REQ_W-1:0] data;
   } req_word_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   midpoint_circle_rasterizer_core #(.COORD_WIDTH(CW)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   // predictor state
   logic signed [15:0] ctr_col, ctr_row, off_x, off_y;
   logic signed [19:0] decision;
   logic fill_on;
   logic [31:0] pen_color;
   logic busy;

   req_word_type pending_words[$];
   rect_type expected_rects[$];
   int fail_count;
   int words_taken;
   int cycle_count;
   bit word_taken;

   function automatic rect_type make_rect(int x, int y, int w, bit last, bit done);
      rect_type r;
      r.x = x[16:0];
      r.y = y[16:0];
      r.w = w[14:0];
      r.h = 1'b1;
      r.color = pen_color;
      r.last = last;
      r.done = done;
      return r;
   endfunction

   task automatic push_group(bit done);
      int cx, cy, ox, oy;
      cx = int'(ctr_col);
      cy = int'(ctr_row);
      ox = int'(off_x);
      oy = int'(off_y);
      if (fill_on) begin
         expected_rects.push_back(make_rect(cx - ox, cy + oy, 2*ox + 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - ox, cy - oy, 2*ox + 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - oy, cy + ox, 2*oy + 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - oy, cy - ox, 2*oy + 1, 1'b1, done));
      end else begin
         expected_rects.push_back(make_rect(cx + ox, cy + oy, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - ox, cy + oy, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx + ox, cy - oy, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - ox, cy - oy, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx + oy, cy + ox, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - oy, cy + ox, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx + oy, cy - ox, 1, 1'b0, done));
         expected_rects.push_back(make_rect(cx - oy, cy - ox, 1, 1'b1, done));
      end
   endtask

   task automatic predict_circle(logic mode, logic [REQ_W-1:0] data);
      int r;
      int d;
      bit done;
      if (mode == MODE_START) begin
         r = int'(data[45:32]);
         ctr_col = data[15:0];
         ctr_row = data[31:16];
         fill_on = data[46];
         pen_color = data[78:47];
         off_x = '0;
         off_y = r[15:0];
         d = 3 - 2*r;
         decision = d[19:0];
         busy = 1'b1;
         push_group(1'b0);
      end else if (busy) begin
         if (decision > 0) begin
            off_y = off_y - 16'sd1;
            d = int'(decision) + 4*(int'(off_x) - int'(off_y)) + 10;
         end else begin
            d = int'(decision) + 4*int'(off_x) + 6;
         end
         decision = d[19:0];
         off_x = off_x + 16'sd1;
         done = off_y < off_x;
         if (done) busy = 1'b0;
         push_group(done);
      end
   endtask

   task automatic add_start(logic [15:0] x, logic [15:0] y, logic [13:0] r,
                            logic fill, logic [31:0] color);
      req_word_type w;
      w.mode = MODE_START;
      w.data = {1'b0, color, fill, r, y, x};
      pending_words.push_back(w);
   endtask

   task automatic add_steps(int n);
      req_word_type w;
      for (int i = 0; i < n; i++) begin
         w.mode = MODE_STEP;
         w.data = REQ_W'({$urandom, $urandom, $urandom});
         w.data[REQ_W-1] = 1'b0;
         pending_words.push_back(w);
      end
   endtask

   // mostly short gaps, a few long, none inside calm stretches
   function automatic int pick_gap();
      int p;
      if ((cycle_count % 512) < 128) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

   // driver
   int req_gap;
   always @(negedge clock) begin
      req_word_type w;
      if (!reset && (!req_tvalid || word_taken)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_tdata <= w.data;
            req_tuser <= w.mode;
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once 60 request words have been taken
   int stall_left;
   int hold_left;
   bit held_once;
   always @(negedge clock) begin
      if (!reset) begin
         if (!held_once && words_taken >= 60) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 99) < 15) ? pick_gap() : 0;
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rect_type got, want;
      cycle_count++;
      word_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[16:0], rsp_tdata[33:17], rsp_tdata[48:34], rsp_tdata[49],
                   rsp_tdata[81:50], rsp_tlast, rsp_tuser};
            if (expected_rects.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rect x=%h y=%h w=%h h=%b color=%h last=%b done=%b",
                           got.x, got.y, got.w, got.h, got.color, got.last, got.done);
            end else begin
               want = expected_rects.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch exp x=%h y=%h w=%h h=%b color=%h last=%b done=%b",
                              want.x, want.y, want.w, want.h, want.color, want.last,
                              want.done);
                     $display("         got x=%h y=%h w=%h h=%b color=%h last=%b done=%b",
                              got.x, got.y, got.w, got.h, got.color, got.last,
                              got.done);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            word_taken = 1'b1;
            words_taken++;
            predict_circle(req_tuser, req_tdata);
         end
      end
   end

   initial begin
      int n, r, kind, steps;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_START;
      rsp_tready = 1'b0;
      fail_count = 0;
      words_taken = 0;
      cycle_count = 0;
      req_gap = 0;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
      ctr_col = '0;
      ctr_row = '0;
      off_x = '0;
      off_y = '0;
      decision = '0;
      fill_on = 1'b0;
      pen_color = '0;
      busy = 1'b0;

      // step while idle, zero radius in both modes, extremes of the fields
      add_steps(1);
      add_start(16'h0000, 16'h0000, 14'd0, 1'b0, 32'h0000_0000);
      add_steps(2);
      add_start(16'h7fff, 16'h8000, 14'd0, 1'b1, 32'hffff_ffff);
      add_steps(1);
      add_start(16'h8000, 16'h7fff, 14'd3, 1'b0, 32'h1234_5678);
      add_steps(4);
      // restart while a circle is still running
      add_start(16'h0100, 16'hff00, 14'd5, 1'b1, 32'h5a5a_5a5a);
      add_steps(1);
      add_start(16'hffff, 16'h0001, 14'h3fff, 1'b0, 32'ha5a5_a5a5);
      add_steps(2);
      add_start(16'h0001, 16'hffff, 14'h3fff, 1'b1, 32'h8000_0001);
      add_steps(1);
      add_start(16'h0010, 16'h0020, 14'd1, 1'b1, 32'h0f0f_f0f0);
      add_steps(3);

      n = 0;
      while (n < NUM_RANDOM) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            steps = $urandom_range(1, 3);
            add_steps(steps);
            n += steps;
         end else begin
            r = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 24)
                                             : $urandom_range(0, 16383);
            add_start(16'($urandom), 16'($urandom), r[13:0],
                      1'($urandom_range(0, 1)), $urandom);
            if (kind < 25)
               steps = $urandom_range(0, r > 24 ? 6 : r);
            else
               steps = (r <= 24) ? (r*3)/4 + 2 : $urandom_range(0, 6);
            add_steps(steps);
            n += steps + 1;
         end
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_rects.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_rects.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
